### rtl/core/srla_pkg.sv
// Package for the scrollback ring line address block.
// Holds the command and answer codes, field widths and sizing constants.
// Depends on nothing.
`default_nettype none

package srla_pkg;

  localparam int unsigned HISTORY_DEPTH  = 1024;
  localparam int unsigned MAX_ROWS       = 256;
  localparam int unsigned RING_LINES_RST = 1000;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned CNT_W    = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH        = 2'd0,
    CMD_SCROLL_UP   = 2'd1,
    CMD_SCROLL_DOWN = 2'd2,
    CMD_QUERY       = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 2'd0,
    KIND_SCREEN  = 2'd1,
    KIND_HISTORY = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [AMOUNT_W-1:0] scroll_amount;
    logic [ROW_W-1:0]    row;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] source_kind;
    logic [ROW_W-1:0]  screen_row;
    logic [SLOT_W-1:0] history_slot;
    logic              write_done;
    logic [CNT_W-1:0]  scroll_position;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/srla_req_if.sv
// Command channel of the scrollback ring line address block.
// Carries valid, ready and the command fields; widths from srla_pkg.
`default_nettype none

interface srla_req_if
  import srla_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [AMOUNT_W-1:0] scroll_amount;
  logic [ROW_W-1:0]    row;

  modport source (output valid, cmd, scroll_amount, row, input ready);
  modport sink   (input valid, cmd, scroll_amount, row, output ready);
endinterface

`default_nettype wire

### rtl/core/srla_rsp_if.sv
// Answer channel of the scrollback ring line address block.
// Carries valid, ready and the answer fields; widths from srla_pkg.
`default_nettype none

interface srla_rsp_if
  import srla_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] source_kind;
  logic [ROW_W-1:0]  screen_row;
  logic [SLOT_W-1:0] history_slot;
  logic              write_done;
  logic [CNT_W-1:0]  scroll_position;

  modport source (output valid, source_kind, screen_row, history_slot, write_done,
                  scroll_position, input ready);
  modport sink   (input valid, source_kind, screen_row, history_slot, write_done,
                  scroll_position, output ready);
endinterface

`default_nettype wire

### rtl/core/scrollback_ring_line_address.sv
// Scrollback ring line address block: write slot, filled count and scroll offset.
// Depends on srla_pkg, srla_req_if and srla_rsp_if.
//
// Usage: commands arrive on req_i (valid/ready); each transaction gives exactly one
// answer transaction on rsp_o. Push returns the ring slot written, scroll up/down
// move the scroll offset, a display query maps a row to a screen line, a history
// slot or nothing. The ring size register is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while idle; the block itself does not enforce this.
// A command passes the input register, then the answer register, before its answer
// is valid. Throughput: one transaction per cycle while rsp_o.ready stays high, set by
// the single combinational pass that reads and updates the three state registers.
// Stall: when rsp_o.ready is low the answer register holds, the input register
// holds one more command, and req_i.ready drops only once both are full.
// Reset: write slot, filled count and scroll offset clear to zero, the ring size
// returns to 1000, both stages empty.
`default_nettype none

module scrollback_ring_line_address
  import srla_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire  [CNT_W-1:0] cfg_wdata_i,
  srla_req_if.sink         req_i,
  srla_rsp_if.source       rsp_o
);

  req_t              req_q;
  logic              req_v_q;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_v_q;
  logic [CNT_W-1:0]  ring_lines_q;
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic [CNT_W-1:0]  filled_q, filled_d;
  logic [CNT_W-1:0]  scroll_q, scroll_d;
  logic              adv;

  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  avail;
  logic [SLOT_W-1:0] oldest;
  logic [CNT_W-1:0]  nxt;
  logic              row_ok;
  logic [16:0]       sum;
  logic [12:0]       tot, h, sy;
  logic [11:0]       act;

  assign adv         = req_v_q && (!rsp_v_q || rsp_o.ready);
  assign req_i.ready = !req_v_q || adv;

  assign size   = (ring_lines_q > CNT_W'(HISTORY_DEPTH)) ? CNT_W'(HISTORY_DEPTH) : ring_lines_q;
  assign avail  = (filled_q < size) ? filled_q : size;
  assign oldest = ({1'b0, write_slot_q} < size) ? write_slot_q : '0;
  assign nxt    = {1'b0, oldest} + CNT_W'(1);
  assign row_ok = {5'b0, req_q.row} < 13'(MAX_ROWS);
  assign sum    = {6'b0, scroll_q} + {1'b0, req_q.scroll_amount};
  assign tot    = {2'b0, avail} + {5'b0, req_q.row};
  assign h      = tot - {2'b0, scroll_q};
  assign sy     = h - {2'b0, avail};
  assign act    = {2'b0, oldest} + {1'b0, h[CNT_W-1:0]};

  always_comb begin
    rsp_d        = '0;
    write_slot_d = write_slot_q;
    filled_d     = filled_q;
    scroll_d     = scroll_q;
    unique case (cmd_e'(req_q.cmd))
      CMD_PUSH: begin
        rsp_d.screen_row = req_q.row;
        if (size != '0 && row_ok) begin
          write_slot_d       = (nxt >= size) ? '0 : nxt[SLOT_W-1:0];
          filled_d           = (filled_q < size) ? filled_q + CNT_W'(1) : size;
          rsp_d.history_slot = oldest;
          rsp_d.write_done   = 1'b1;
        end
      end
      CMD_SCROLL_UP: begin
        scroll_d = (sum > {6'b0, avail}) ? avail : sum[CNT_W-1:0];
      end
      CMD_SCROLL_DOWN: begin
        scroll_d = ({5'b0, scroll_q} < req_q.scroll_amount) ? '0
                 : scroll_q - req_q.scroll_amount[CNT_W-1:0];
      end
      CMD_QUERY: begin
        if (scroll_q == '0) begin
          if (row_ok) begin
            rsp_d.source_kind = KIND_SCREEN;
            rsp_d.screen_row  = req_q.row;
          end
        end else if (filled_q != '0 && size != '0 && tot >= {2'b0, scroll_q}) begin
          if (h >= {2'b0, avail}) begin
            if (sy < 13'(MAX_ROWS)) begin
              rsp_d.source_kind = KIND_SCREEN;
              rsp_d.screen_row  = sy[ROW_W-1:0];
            end
          end else begin
            rsp_d.source_kind = KIND_HISTORY;
            if (filled_q < size) begin
              rsp_d.history_slot = h[SLOT_W-1:0];
            end else if (act >= {1'b0, size}) begin
              rsp_d.history_slot = SLOT_W'(act - {1'b0, size});
            end else begin
              rsp_d.history_slot = act[SLOT_W-1:0];
            end
          end
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
    rsp_d.scroll_position = scroll_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q      <= 1'b0;
      rsp_v_q      <= 1'b0;
      ring_lines_q <= CNT_W'(RING_LINES_RST);
      write_slot_q <= '0;
      filled_q     <= '0;
      scroll_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        ring_lines_q <= cfg_wdata_i;
      end
      if (req_i.valid && req_i.ready) begin
        req_v_q <= 1'b1;
      end else if (adv) begin
        req_v_q <= 1'b0;
      end
      if (adv) begin
        rsp_v_q      <= 1'b1;
        write_slot_q <= write_slot_d;
        filled_q     <= filled_d;
        scroll_q     <= scroll_d;
      end else if (rsp_o.ready) begin
        rsp_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q.cmd           <= req_i.cmd;
      req_q.scroll_amount <= req_i.scroll_amount;
      req_q.row           <= req_i.row;
    end
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid           = rsp_v_q;
  assign rsp_o.source_kind     = rsp_q.source_kind;
  assign rsp_o.screen_row      = rsp_q.screen_row;
  assign rsp_o.history_slot    = rsp_q.history_slot;
  assign rsp_o.write_done      = rsp_q.write_done;
  assign rsp_o.scroll_position = rsp_q.scroll_position;

endmodule

`default_nettype wire

### rtl/core/srla_checker.sv
// Port-level checks for the scrollback ring line address block.
// Depends on srla_pkg; bound to scrollback_ring_line_address below.
`default_nettype none

module srla_checker
  import srla_pkg::*;
(
  input wire              clk_i,
  input wire              rst_ni,
  input wire              rsp_valid_i,
  input wire              rsp_ready_i,
  input wire [KIND_W-1:0] source_kind_i,
  input wire [ROW_W-1:0]  screen_row_i,
  input wire [SLOT_W-1:0] history_slot_i,
  input wire              write_done_i,
  input wire [CNT_W-1:0]  scroll_position_i
);

  a_push_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && write_done_i) |-> (source_kind_i == KIND_NONE))
    else $error("push answer carries a display kind");

  a_hist_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && source_kind_i == KIND_HISTORY) |-> (screen_row_i == '0 && !write_done_i))
    else $error("history answer carries screen row or write flag");

  a_screen_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && source_kind_i == KIND_SCREEN) |-> (history_slot_i == '0 && !write_done_i))
    else $error("screen answer carries history slot or write flag");

  a_scroll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (scroll_position_i <= CNT_W'(HISTORY_DEPTH)))
    else $error("scroll position beyond history depth");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(scroll_position_i)))
    else $error("stalled answer changed");

endmodule

bind scrollback_ring_line_address srla_checker u_srla_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .source_kind_i     (rsp_o.source_kind),
  .screen_row_i      (rsp_o.screen_row),
  .history_slot_i    (rsp_o.history_slot),
  .write_done_i      (rsp_o.write_done),
  .scroll_position_i (rsp_o.scroll_position)
);

`default_nettype wire

### tb/srla_answer_checker.sv
// Answer checker for the scrollback ring line address block.
// Watches the command and answer channels and the ring size write port,
// predicts each answer and compares it; depends on srla_pkg and both channel interfaces.
`timescale 1ns / 100ps

module srla_answer_checker
  import srla_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  srla_req_if              req_i,
  srla_rsp_if              rsp_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int DEPTH = HISTORY_DEPTH;
  localparam int ROWS  = MAX_ROWS;

  int   ring_lines = RING_LINES_RST;
  int   wr_slot    = 0;
  int   filled     = 0;
  int   offset     = 0;
  int   errors     = 0;
  int   in_flight  = 0;
  rsp_t answers_due[$];

  assign errors_o  = errors;
  assign pending_o = in_flight;

  function automatic rsp_t resolve_line_address(cmd_e op, logic [AMOUNT_W-1:0] amount,
                                                logic [ROW_W-1:0] row);
    rsp_t a;
    int   size;
    int   avail;
    int   sum;
    int   hl;
    int   slot;
    a     = '0;
    size  = (ring_lines < DEPTH) ? ring_lines : DEPTH;
    avail = (filled < size) ? filled : size;
    case (op)
      CMD_PUSH: begin
        a.screen_row = row;
        if (size != 0 && int'(row) < ROWS) begin
          slot           = (wr_slot < size) ? wr_slot : 0;
          a.history_slot = slot[SLOT_W-1:0];
          a.write_done   = 1'b1;
          wr_slot        = (slot + 1 >= size) ? 0 : slot + 1;
          filled         = (filled < size) ? filled + 1 : size;
        end
      end
      CMD_SCROLL_UP: begin
        sum    = offset + int'(amount);
        offset = (sum > avail) ? avail : sum;
      end
      CMD_SCROLL_DOWN: begin
        offset = (int'(amount) > offset) ? 0 : offset - int'(amount);
      end
      default: begin
        if (offset == 0) begin
          if (int'(row) < ROWS) begin
            a.source_kind = KIND_SCREEN;
            a.screen_row  = row;
          end
        end else if (filled != 0 && size != 0) begin
          hl = avail - offset + int'(row);
          if (hl >= avail) begin
            if (hl - avail < ROWS) begin
              a.source_kind = KIND_SCREEN;
              slot          = hl - avail;
              a.screen_row  = slot[ROW_W-1:0];
            end
          end else if (hl >= 0) begin
            if (filled < size) begin
              slot = hl;
            end else begin
              slot = ((wr_slot < size) ? wr_slot : 0) + hl;
              if (slot >= size) slot -= size;
            end
            a.source_kind  = KIND_HISTORY;
            a.history_slot = slot[SLOT_W-1:0];
          end
        end
      end
    endcase
    a.scroll_position = offset[CNT_W-1:0];
    return a;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    rsp_t want;
    if (!rst_ni) begin
      ring_lines = RING_LINES_RST;
      wr_slot    = 0;
      filled     = 0;
      offset     = 0;
      in_flight  = 0;
      answers_due.delete();
    end else begin
      if (cfg_we_i) ring_lines = int'(cfg_wdata_i);
      if (req_i.valid && req_i.ready) begin
        answers_due.push_back(resolve_line_address(cmd_e'(req_i.cmd), req_i.scroll_amount,
                                                   req_i.row));
        in_flight++;
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (answers_due.size() == 0) begin
          $error("answer transaction with no command outstanding");
          errors++;
        end else begin
          want = answers_due.pop_front();
          in_flight--;
          check_field("source_kind", 32'(want.source_kind), 32'(rsp_i.source_kind));
          check_field("screen_row", 32'(want.screen_row), 32'(rsp_i.screen_row));
          check_field("history_slot", 32'(want.history_slot), 32'(rsp_i.history_slot));
          check_field("write_done", 32'(want.write_done), 32'(rsp_i.write_done));
          check_field("scroll_position", 32'(want.scroll_position),
                      32'(rsp_i.scroll_position));
        end
      end
    end
  end

endmodule

### tb/tb_scrollback_ring_line_address.sv
// Top of the scrollback ring line address testbench: clock, reset, command and
// ring size stimulus, answer back-pressure and the verdict.
// Depends on srla_pkg, both channel interfaces, the block and srla_answer_checker.
`timescale 1ns / 100ps

module tb_scrollback_ring_line_address;
  import srla_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 55;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  int               errors;
  int               pending;
  int               cycles;
  int               items_sent;
  bit               quiet;
  int               cur_size;

  srla_req_if req_if ();
  srla_rsp_if rsp_if ();

  scrollback_ring_line_address uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  srla_answer_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Answer side: short random stalls, one long hold to back the block up.
  initial begin
    int  hold_cnt;
    bit  long_hold_done;
    hold_cnt       = 0;
    long_hold_done = 0;
    rsp_if.ready   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && items_sent >= 120) begin
        long_hold_done = 1;
        hold_cnt       = 60;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && rst_ni && $urandom_range(0, 7) == 0) begin
        hold_cnt     = $urandom_range(0, 5);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(cmd_e op, logic [AMOUNT_W-1:0] amount, logic [ROW_W-1:0] row);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.cmd           <= op;
    req_if.scroll_amount <= amount;
    req_if.row           <= row;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic drain;
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_size(int value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[CNT_W-1:0];
    cur_size    = (value < int'(HISTORY_DEPTH)) ? value : int'(HISTORY_DEPTH);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_cmd;
    int               pick;
    int               span;
    logic [AMOUNT_W-1:0] amount;
    logic [ROW_W-1:0]    row;
    span = $urandom_range(0, 9);
    if (span < 5) amount = AMOUNT_W'($urandom_range(0, 8));
    else if (span < 9) amount = AMOUNT_W'($urandom_range(0, cur_size + 4));
    else amount = AMOUNT_W'($urandom());
    span = cur_size + 8;
    if (span > 255) span = 255;
    row  = ROW_W'(($urandom_range(0, 9) < 6) ? $urandom_range(0, span)
                                             : $urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 35) send_cmd(CMD_PUSH, amount, row);
    else if (pick < 50) send_cmd(CMD_SCROLL_UP, amount, row);
    else if (pick < 60) send_cmd(CMD_SCROLL_DOWN, amount, row);
    else send_cmd(CMD_QUERY, amount, row);
  endtask

  initial begin
    int phase_size[9];
    phase_size           = '{7, 1, 2047, 0, 13, 1024, 2, 1000, 4};
    items_sent           = 0;
    quiet                = 0;
    cur_size             = RING_LINES_RST;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    req_if.valid         = 1'b0;
    req_if.cmd           = CMD_PUSH;
    req_if.scroll_amount = '0;
    req_if.row           = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size, empty history.
    send_cmd(CMD_QUERY, 16'd0, 8'd0);
    send_cmd(CMD_QUERY, 16'd0, 8'd255);
    send_cmd(CMD_SCROLL_UP, 16'd3, 8'd0);
    send_cmd(CMD_PUSH, 16'd0, 8'd0);
    send_cmd(CMD_PUSH, 16'hFFFF, 8'd255);
    send_cmd(CMD_PUSH, 16'd0, 8'd17);
    send_cmd(CMD_PUSH, 16'd0, 8'd42);
    send_cmd(CMD_PUSH, 16'd0, 8'd100);
    send_cmd(CMD_SCROLL_UP, 16'hFFFF, 8'd0);
    send_cmd(CMD_QUERY, 16'd0, 8'd0);
    send_cmd(CMD_QUERY, 16'd0, 8'd4);
    send_cmd(CMD_QUERY, 16'd0, 8'd5);
    send_cmd(CMD_QUERY, 16'd0, 8'd255);
    // Shrink below the filled count and write slot while scrolled back.
    write_size(3);
    send_cmd(CMD_QUERY, 16'd0, 8'd0);
    send_cmd(CMD_QUERY, 16'd0, 8'd3);
    send_cmd(CMD_PUSH, 16'd0, 8'd9);
    send_cmd(CMD_SCROLL_UP, 16'd0, 8'd0);
    send_cmd(CMD_SCROLL_DOWN, 16'hFFFF, 8'd0);
    send_cmd(CMD_SCROLL_UP, 16'd1, 8'd0);
    // Disable history while scrolled.
    write_size(0);
    send_cmd(CMD_QUERY, 16'd0, 8'd0);
    send_cmd(CMD_PUSH, 16'd0, 8'd7);
    send_cmd(CMD_SCROLL_UP, 16'd0, 8'd0);
    send_cmd(CMD_QUERY, 16'd0, 8'd255);
    write_size(2047);
    send_cmd(CMD_PUSH, 16'd0, 8'd1);

    for (int p = 0; p < 9; p++) begin
      write_size(phase_size[p]);
      quiet = (p == 8);
      repeat (PHASE_ITEMS) random_cmd();
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### scrollback_ring_line_address.f
rtl/core/srla_pkg.sv
rtl/core/srla_req_if.sv
rtl/core/srla_rsp_if.sv
rtl/core/scrollback_ring_line_address.sv
rtl/core/srla_checker.sv
tb/srla_answer_checker.sv
tb/tb_scrollback_ring_line_address.sv
